>>> hw/rtl/cart_bank_ram_pen_convert_defines.svh
// Assertion macros for the cartridge bus slave.
`ifndef CART_BANK_RAM_PEN_CONVERT_DEFINES_SVH
`define CART_BANK_RAM_PEN_CONVERT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while arst_n is low
`define CBRPC_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbrpc assertion failed");
// next-cycle implication
`define CBRPC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbrpc assertion failed");
`else
`define CBRPC_ASSERT_NOW(lbl, ante, cons)
`define CBRPC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hw/rtl/cbrpc_pkg.sv
// Types, constants and pen helpers shared by the cartridge bus slave.
`default_nettype none
package cbrpc_pkg;

	localparam int unsigned ADDR_W = 24;
	localparam int unsigned WORD_W = 16;
	localparam int unsigned LOW_W = 20;
	localparam int unsigned RAM_AW = 12;
	localparam int unsigned RAM_WORDS = 1 << RAM_AW;
	localparam int unsigned REG_AW = 4;
	localparam int unsigned REG_COUNT = 1 << REG_AW;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic CMD_READ = 1'b0;
	localparam logic CMD_WRITE = 1'b1;

	localparam logic [1:0] SRC_RAM = 2'd0;
	localparam logic [1:0] SRC_FIXED = 2'd1;
	localparam logic [1:0] SRC_BANKED = 2'd2;
	localparam logic [1:0] SRC_OPEN = 2'd3;

	// address decode tags
	localparam logic [10:0] WIN_TAG = 11'h17f;   // addr[23:13] of 0x2fe000..0x2fffff
	localparam logic [3:0] FIXED_TAG = 4'h0;     // addr[23:20] below 0x100000
	localparam logic [3:0] BANK_TAG = 4'h2;      // addr[23:20] of 0x200000..
	localparam logic [7:0] REG_TAG = 8'hff;      // word[11:4] of 0xff0..0xfff

	// helper register slots within 0xff0..0xfff
	localparam logic [REG_AW-1:0] REG_PEN = 4'h0;
	localparam logic [REG_AW-1:0] REG_UNP_GB = 4'h1;
	localparam logic [REG_AW-1:0] REG_UNP_SR = 4'h2;
	localparam logic [REG_AW-1:0] REG_PK_GB = 4'h4;
	localparam logic [REG_AW-1:0] REG_PK_SR = 4'h5;
	localparam logic [REG_AW-1:0] REG_PACKED = 4'h6;
	localparam logic [REG_AW-1:0] REG_BANK_LO = 4'h8;
	localparam logic [REG_AW-1:0] REG_BANK_HI = 4'h9;

	localparam logic [ADDR_W-1:0] BANK_OFS = 24'h100000;
	localparam logic [WORD_W-1:0] BANK_KEEP_MASK = 16'hfe00;
	localparam logic [WORD_W-1:0] BANK_FILL = 16'h00a0;
	localparam logic [WORD_W-1:0] BANK_HI_MASK = 16'h7fff;

	typedef struct packed {
		logic command;
		logic upper_lane;
		logic lower_lane;
		logic [ADDR_W-1:0] bus_address;
		logic [WORD_W-1:0] bus_data;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] read_data;
		logic [1:0] source;
		logic [ADDR_W-1:0] rom_word_address;
	} rsp_t;

	// classified item handed from front to back
	typedef struct packed {
		logic is_write;
		logic upper_lane;
		logic lower_lane;
		logic [1:0] source;
		logic [LOW_W-1:0] addr_lo;
		logic [WORD_W-1:0] bus_data;
	} op_t;

	function automatic logic [WORD_W-1:0] pen_unpack_gb(input logic [WORD_W-1:0] pen);
		logic [4:0] b;
		logic [4:0] g;
		b = {pen[3:0], pen[12]};
		g = {pen[7:4], pen[13]};
		return {3'b000, g, 3'b000, b};
	endfunction

	function automatic logic [WORD_W-1:0] pen_unpack_sr(input logic [WORD_W-1:0] pen);
		logic [4:0] r;
		r = {pen[11:8], pen[14]};
		return {7'b0000000, pen[15], 3'b000, r};
	endfunction

	function automatic logic [WORD_W-1:0] pen_pack(input logic [WORD_W-1:0] gb,
			input logic [WORD_W-1:0] sr);
		return {sr[8], sr[0], gb[8], gb[0], sr[4:1], gb[12:9], gb[4:1]};
	endfunction

endpackage
`default_nettype wire

>>> hw/rtl/cbrpc_front.sv
// Front end: decodes each bus access and queues the ones that need work.
`default_nettype none
module cbrpc_front (
	input  wire cbrpc_pkg::req_t req,
	input  wire                  req_valid,
	output logic                 req_ready,
	input  wire                  q_ready,
	input  wire                  init_done,
	output cbrpc_pkg::op_t       op,
	output logic                 push
);
	import cbrpc_pkg::*;

	logic in_win;
	logic is_fixed;
	logic is_banked;
	logic keep;

	always_comb begin
		in_win = req.bus_address[ADDR_W-1:13] == WIN_TAG;
		is_fixed = req.bus_address[ADDR_W-1:LOW_W] == FIXED_TAG;
		is_banked = (req.bus_address[ADDR_W-1:LOW_W] == BANK_TAG) && !in_win;

		op.is_write = req.command == CMD_WRITE;
		op.upper_lane = req.upper_lane;
		op.lower_lane = req.lower_lane;
		op.addr_lo = req.bus_address[LOW_W-1:0];
		op.bus_data = req.bus_data;
		if (in_win) begin
			op.source = SRC_RAM;
		end else if (is_fixed) begin
			op.source = SRC_FIXED;
		end else if (is_banked) begin
			op.source = SRC_BANKED;
		end else begin
			op.source = SRC_OPEN;
		end

		// writes outside the window are taken and dropped
		keep = (req.command == CMD_READ) || in_win;
		req_ready = q_ready && init_done;
		push = req_valid && req_ready && keep;
	end

endmodule
`default_nettype wire

>>> hw/rtl/cbrpc_queue.sv
// Small FIFO of decoded items between front and back.
`default_nettype none
module cbrpc_queue #(
	parameter int unsigned DEPTH = cbrpc_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire cbrpc_pkg::op_t  push_op,
	output logic                 ready,
	output logic                 valid,
	output cbrpc_pkg::op_t       head,
	input  wire                  pop
);
	import cbrpc_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	op_t entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign ready = count_q != CNT_W'(DEPTH);
	assign valid = count_q != '0;
	assign head = entry_q[rd_ptr_q];
	assign do_push = push && ready;
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> hw/rtl/cbrpc_back.sv
// Back end: window RAM, helper registers, bank base and the result stages.
`default_nettype none
module cbrpc_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire cbrpc_pkg::op_t  op,
	input  wire                  op_valid,
	output logic                 op_pop,
	output logic                 init_done,
	output logic                 rsp_valid,
	input  wire                  rsp_ready,
	output cbrpc_pkg::rsp_t      rsp
);
	import cbrpc_pkg::*;

	// window RAM, cleared by a sweep after reset
	logic [WORD_W-1:0] ram_mem [RAM_WORDS];
	logic [WORD_W-1:0] ram_rd_q;
	logic [RAM_AW-1:0] clr_idx_q;
	logic init_done_q;

	// helper words 0xff0..0xfff live in flops
	logic [WORD_W-1:0] sp_q [REG_COUNT];
	logic [WORD_W-1:0] sp_d [REG_COUNT];
	logic [ADDR_W-1:0] bank_q;
	logic [ADDR_W-1:0] bank_d;

	logic [RAM_AW-1:0] word;
	logic [REG_AW-1:0] reg_idx;
	logic is_reg;
	logic [WORD_W-1:0] cur;
	logic [WORD_W-1:0] merged;
	logic out_can;
	logic s1_go;
	logic wr_fire;
	logic rd_fire;

	logic mem_we_hi;
	logic mem_we_lo;
	logic [RAM_AW-1:0] mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic ram_re;

	logic s1_valid_q;
	logic [1:0] src_s1;
	logic use_ram_s1;
	logic [WORD_W-1:0] data_s1;
	logic [ADDR_W-1:0] rom_s1;
	logic [ADDR_W:0] bank_sum;

	logic out_valid_q;
	rsp_t out_q;

	assign word = op.addr_lo[RAM_AW:1];
	assign reg_idx = word[REG_AW-1:0];
	assign is_reg = word[RAM_AW-1:REG_AW] == REG_TAG;
	assign cur = sp_q[reg_idx];
	assign merged = {op.upper_lane ? op.bus_data[15:8] : cur[15:8],
			op.lower_lane ? op.bus_data[7:0] : cur[7:0]};

	assign out_can = !out_valid_q || rsp_ready;
	assign s1_go = !s1_valid_q || out_can;
	// writes make no result, so they never wait on the output side
	assign op_pop = op_valid && init_done_q && (op.is_write || s1_go);
	assign wr_fire = op_pop && op.is_write;
	assign rd_fire = op_pop && !op.is_write;
	assign init_done = init_done_q;

	always_comb begin
		if (!init_done_q) begin
			mem_we_hi = 1'b1;
			mem_we_lo = 1'b1;
			mem_addr = clr_idx_q;
			mem_wdata = '0;
		end else begin
			mem_we_hi = wr_fire && !is_reg && op.upper_lane;
			mem_we_lo = wr_fire && !is_reg && op.lower_lane;
			mem_addr = word;
			mem_wdata = op.bus_data;
		end
		ram_re = rd_fire && (op.source == SRC_RAM) && !is_reg;
	end

	always_ff @(posedge clk) begin
		if (mem_we_hi) begin
			ram_mem[mem_addr][15:8] <= mem_wdata[15:8];
		end
		if (mem_we_lo) begin
			ram_mem[mem_addr][7:0] <= mem_wdata[7:0];
		end
		if (ram_re) begin
			ram_rd_q <= ram_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_idx_q <= '0;
			init_done_q <= 1'b0;
		end else if (!init_done_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == '1) begin
				init_done_q <= 1'b1;
			end
		end
	end

	// helper register side effects use the freshly written word
	always_comb begin
		sp_d = sp_q;
		bank_d = bank_q;
		if (wr_fire && is_reg) begin
			sp_d[reg_idx] = merged;
			if (reg_idx == REG_PEN) begin
				sp_d[REG_UNP_GB] = pen_unpack_gb(merged);
				sp_d[REG_UNP_SR] = pen_unpack_sr(merged);
			end
			if (reg_idx == REG_PK_GB || reg_idx == REG_PK_SR) begin
				sp_d[REG_PACKED] = pen_pack(sp_d[REG_PK_GB], sp_d[REG_PK_SR]);
			end
			if (reg_idx >= REG_BANK_LO) begin
				bank_d = {sp_d[REG_BANK_HI], sp_d[REG_BANK_LO][15:8]} + BANK_OFS;
				sp_d[REG_BANK_LO] = (sp_d[REG_BANK_LO] & BANK_KEEP_MASK) | BANK_FILL;
				sp_d[REG_BANK_HI] = sp_d[REG_BANK_HI] & BANK_HI_MASK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < REG_COUNT; i++) begin
				sp_q[i] <= '0;
			end
			bank_q <= BANK_OFS;
		end else begin
			sp_q <= sp_d;
			bank_q <= bank_d;
		end
	end

	// banked ROM: sum is one bit wider, word index drops bit 0
	assign bank_sum = {1'b0, bank_q} + {{(ADDR_W + 1 - LOW_W){1'b0}}, op.addr_lo};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s1_go) begin
			s1_valid_q <= rd_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_fire) begin
			src_s1 <= op.source;
			use_ram_s1 <= (op.source == SRC_RAM) && !is_reg;
			case (op.source)
				SRC_RAM: begin
					data_s1 <= cur;
					rom_s1 <= '0;
				end
				SRC_FIXED: begin
					data_s1 <= '0;
					rom_s1 <= {{(ADDR_W + 1 - LOW_W){1'b0}}, op.addr_lo[LOW_W-1:1]};
				end
				SRC_BANKED: begin
					data_s1 <= '0;
					rom_s1 <= bank_sum[ADDR_W:1];
				end
				SRC_OPEN: begin
					data_s1 <= op.bus_data;
					rom_s1 <= '0;
				end
				default: begin
					data_s1 <= op.bus_data;
					rom_s1 <= '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_valid_q && out_can) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_valid_q && out_can) begin
			out_q.read_data <= use_ram_s1 ? ram_rd_q : data_s1;
			out_q.source <= src_s1;
			out_q.rom_word_address <= rom_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

endmodule
`default_nettype wire

>>> hw/rtl/cart_bank_ram_pen_convert.sv
// Top level of the cartridge bus slave: front decode, queue, back end.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   cbrpc_pkg::req_t (read or write access)
//   rsp      out  rsp_valid/rsp_ready   cbrpc_pkg::rsp_t (one per read access)
//
// One access per cycle is taken while the queue has room and the sweep is done; a read's result
// goes from the queue pop into s1 and the RAM read register, then the output register, behind any queued items.
// After reset a sweep clears the 4096-word window RAM, one word a cycle: req_ready stays
// low until the sweep ends. A stalled rsp channel backs up s1 and then the 2-entry queue;
// writes keep draining from the queue while a result waits.
`default_nettype none
`include "cart_bank_ram_pen_convert_defines.svh"
module cart_bank_ram_pen_convert #(
	parameter int unsigned QUEUE_DEPTH = cbrpc_pkg::QUEUE_DEPTH
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire cbrpc_pkg::req_t req,
	input  wire                  req_valid,
	output logic                 req_ready,
	output cbrpc_pkg::rsp_t      rsp,
	output logic                 rsp_valid,
	input  wire                  rsp_ready
);
	import cbrpc_pkg::*;

	op_t push_op;
	op_t head_op;
	logic push;
	logic q_ready;
	logic q_valid;
	logic pop;
	logic init_done;

	cbrpc_front u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.q_ready   (q_ready),
		.init_done (init_done),
		.op        (push_op),
		.push      (push)
	);

	cbrpc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.ready   (q_ready),
		.valid   (q_valid),
		.head    (head_op),
		.pop     (pop)
	);

	cbrpc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (head_op),
		.op_valid  (q_valid),
		.op_pop    (pop),
		.init_done (init_done),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	`CBRPC_ASSERT_NOW(a_no_take_in_sweep, !init_done, !req_ready)
	`CBRPC_ASSERT_NEXT(a_sweep_once, init_done, init_done)
	`CBRPC_ASSERT_NOW(a_rom_no_data, rsp_valid && (rsp.source == SRC_FIXED || rsp.source == SRC_BANKED), rsp.read_data == '0)
	`CBRPC_ASSERT_NOW(a_data_no_rom, rsp_valid && (rsp.source == SRC_RAM || rsp.source == SRC_OPEN), rsp.rom_word_address == '0)

endmodule
`default_nettype wire
